// File: hw/rtl/mbs_pkg.sv
// shared types and constants for the multipart boundary scanner
// no dependencies
package mbs_pkg;

    localparam int MAX_BOUNDARY_DEF = 32;
    localparam int BLEN_W           = 6;
    localparam int BWORD_W          = 64;
    localparam int NUM_BWORDS       = 4;
    localparam int BOUND_BYTES      = 32;
    localparam int CFG_IDX_W        = 3;
    localparam int BYTE_W           = 8;

    localparam logic [BYTE_W-1:0] DASH_CHAR = 8'h2D;

    localparam logic [BLEN_W-1:0] BLEN_RESET = 6'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD3 = 3'd4;

    localparam logic KIND_CONTENT  = 1'b0;
    localparam logic KIND_BOUNDARY = 1'b1;

    typedef struct packed {
        logic              last;
        logic [BYTE_W-1:0] data;
        logic              kind;
    } t_result;

endpackage

// File: hw/rtl/multipart_boundary_scanner.sv
// multipart boundary scanner top level: config registers, core and output skid
// depends on mbs_pkg, mbs_core, mbs_skid
// output path: a direct result beat is registered in the skid buffer; flush beats come from the held-byte store
// throughput: one body byte per cycle while the output accepts; a mismatch flush of n held bytes blocks
// input while the held-byte store drains, one beat per cycle while the output accepts
// reset: synchronous active low, clears candidate state and config to defaults
module multipart_boundary_scanner #(
    parameter int MAX_BOUNDARY = mbs_pkg::MAX_BOUNDARY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [7:0] body_byte
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [7:0]                        o_m_tdata,   // [7:0] content_byte
    output logic                              o_m_tuser,   // [0] kind
    output logic                              o_m_tlast,
    input  logic                              i_cfg_we,
    input  logic [mbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mbs_pkg::BWORD_W-1:0]       i_cfg_wdata
);
    import mbs_pkg::*;

    logic [BLEN_W-1:0]  r_blen;
    logic [BWORD_W-1:0] r_bword [NUM_BWORDS];
    logic [BOUND_BYTES*BYTE_W-1:0] bound;

    logic    res_valid;
    logic    res_ready;
    t_result res;
    t_result out_res;

    assign bound = {r_bword[3], r_bword[2], r_bword[1], r_bword[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blen <= BLEN_RESET;
            for (int i = 0; i < NUM_BWORDS; i++) begin
                r_bword[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEN:   r_blen     <= i_cfg_wdata[BLEN_W-1:0];
                CFG_WORD0: r_bword[0] <= i_cfg_wdata;
                CFG_WORD1: r_bword[1] <= i_cfg_wdata;
                CFG_WORD2: r_bword[2] <= i_cfg_wdata;
                CFG_WORD3: r_bword[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    mbs_core #(
        .MAX_BOUNDARY(MAX_BOUNDARY)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_in_byte   (i_s_tdata),
        .i_blen      (r_blen),
        .i_bound     (bound),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    mbs_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_data  (res),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (out_res)
    );

    assign o_m_tdata = out_res.data;
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.last;

endmodule

// File: hw/rtl/mbs_skid.sv
// output skid buffer: registered result beat plus one spare entry
// depends on mbs_pkg
module mbs_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  mbs_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output mbs_pkg::t_result o_data
);
    import mbs_pkg::*;

    logic    r_valid;
    logic    r_sk_valid;
    t_result r_data;
    t_result r_sk_data;

    assign o_ready = !r_sk_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_sk_valid <= 1'b0;
        end else begin
            if (!r_valid || i_ready) begin
                if (r_sk_valid) begin
                    r_valid    <= 1'b1;
                    r_sk_valid <= 1'b0;
                end else begin
                    r_valid <= i_valid;
                end
            end else if (i_valid && !r_sk_valid) begin
                r_sk_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_valid || i_ready) begin
            r_data <= r_sk_valid ? r_sk_data : i_data;
        end else if (i_valid && !r_sk_valid) begin
            r_sk_data <= i_data;
        end
    end

endmodule

// File: hw/rtl/mbs_core.sv
// candidate tracking, boundary compare and held-byte flush sequencer
// depends on mbs_pkg
module mbs_core #(
    parameter int MAX_BOUNDARY = mbs_pkg::MAX_BOUNDARY_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    output logic                                       o_in_ready,
    input  logic [mbs_pkg::BYTE_W-1:0]                 i_in_byte,
    input  logic [mbs_pkg::BLEN_W-1:0]                 i_blen,
    input  logic [mbs_pkg::BOUND_BYTES*mbs_pkg::BYTE_W-1:0] i_bound,
    output logic                                       o_res_valid,
    input  logic                                       i_res_ready,
    output mbs_pkg::t_result                           o_res
);
    import mbs_pkg::*;

    localparam int IW = (MAX_BOUNDARY > 2) ? $clog2(MAX_BOUNDARY) : 1;
    localparam int CW = $clog2(MAX_BOUNDARY + 1);
    localparam int LW = (CW > BLEN_W) ? CW : BLEN_W;

    logic              r_in_cand;
    logic [CW-1:0]     r_cnt;
    logic              r_flush;
    logic [IW-1:0]     r_fidx;
    logic [CW-1:0]     r_flen;
    logic [BYTE_W-1:0] r_held [MAX_BOUNDARY];

    logic              n_in_cand;
    logic [CW-1:0]     n_cnt;
    logic              n_flush;
    logic [IW-1:0]     n_fidx;
    logic [CW-1:0]     n_flen;

    logic              take;
    logic [LW-1:0]     len_ext;
    logic [CW-1:0]     len;
    logic [CW-1:0]     cnt_inc;
    logic [MAX_BOUNDARY-1:0] eq;
    logic              match;
    logic              flush_last;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;

    assign o_in_ready = !r_flush && i_res_ready;
    assign take       = i_in_valid && o_in_ready;

    // clamp length to 2..MAX_BOUNDARY
    always_comb begin
        len_ext = LW'(i_blen);
        if (len_ext < LW'(2)) begin
            len_ext = LW'(2);
        end else if (len_ext > LW'(MAX_BOUNDARY)) begin
            len_ext = LW'(MAX_BOUNDARY);
        end
        len = CW'(len_ext);
    end

    assign cnt_inc = r_cnt + CW'(1);

    for (genvar g = 0; g < MAX_BOUNDARY; g++) begin : g_cmp
        logic [BYTE_W-1:0] cand;
        logic [BYTE_W-1:0] bb;
        assign cand = (r_cnt == CW'(g)) ? i_in_byte : r_held[g];
        if (g < BOUND_BYTES) begin : g_cfg
            assign bb = i_bound[g*BYTE_W +: BYTE_W];
        end else begin : g_zero
            assign bb = '0;
        end
        assign eq[g] = (CW'(g) >= len) || (cand == bb);
    end

    assign match      = (cnt_inc == len) && (&eq);
    assign flush_last = ((CW'(r_fidx) + CW'(1)) == r_flen);

    assign wr_en  = take && (r_in_cand || (i_in_byte == DASH_CHAR));
    assign wr_idx = r_in_cand ? r_cnt[IW-1:0] : '0;

    always_comb begin
        n_in_cand   = r_in_cand;
        n_cnt       = r_cnt;
        n_flush     = r_flush;
        n_fidx      = r_fidx;
        n_flen      = r_flen;
        o_res_valid = 1'b0;
        o_res.kind  = KIND_CONTENT;
        o_res.data  = '0;
        o_res.last  = 1'b0;
        if (r_flush) begin
            o_res_valid = 1'b1;
            o_res.data  = r_held[r_fidx];
            o_res.last  = flush_last;
            if (i_res_ready) begin
                if (flush_last) begin
                    n_flush = 1'b0;
                end else begin
                    n_fidx = r_fidx + IW'(1);
                end
            end
        end else if (take) begin
            if (!r_in_cand) begin
                if (i_in_byte == DASH_CHAR) begin
                    n_in_cand = 1'b1;
                    n_cnt     = CW'(1);
                end else begin
                    o_res_valid = 1'b1;
                    o_res.data  = i_in_byte;
                    o_res.last  = 1'b1;
                end
            end else if (cnt_inc < len) begin
                n_cnt = cnt_inc;
            end else begin
                n_in_cand = 1'b0;
                n_cnt     = '0;
                if (match) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_BOUNDARY;
                    o_res.last  = 1'b1;
                end else begin
                    n_flush = 1'b1;
                    n_fidx  = '0;
                    n_flen  = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cand <= 1'b0;
            r_cnt     <= '0;
            r_flush   <= 1'b0;
            r_fidx    <= '0;
            r_flen    <= '0;
        end else begin
            r_in_cand <= n_in_cand;
            r_cnt     <= n_cnt;
            r_flush   <= n_flush;
            r_fidx    <= n_fidx;
            r_flen    <= n_flen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_held[wr_idx] <= i_in_byte;
        end
    end

    a_cand_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_cand |-> (r_cnt != '0) && (r_cnt < CW'(MAX_BOUNDARY)))
        else $error("candidate count out of range");

    a_idle_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_cand |-> (r_cnt == '0))
        else $error("count left over outside candidate");

    a_flush_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (CW'(r_fidx) < r_flen) && !r_in_cand)
        else $error("flush index past held bytes");

    a_bnd_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == KIND_BOUNDARY)) |-> o_res.last && (o_res.data == '0))
        else $error("boundary beat malformed");

endmodule

// File: bench/multipart_boundary_scanner_test.sv
// self-checking bench for multipart_boundary_scanner: directed and random body streams,
// own scanner prediction, per-beat compare on the result stream
// depends on mbs_pkg and multipart_boundary_scanner
`timescale 1ns / 100ps

module multipart_boundary_scanner_test;

    import mbs_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata   = 8'h00;   // [7:0] body_byte
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [7:0]           o_m_tdata;             // [7:0] content_byte
    logic                 o_m_tuser;             // [0] kind
    logic                 o_m_tlast;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_LEN;
    logic [BWORD_W-1:0]   i_cfg_wdata = '0;

    multipart_boundary_scanner uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // scanner state and register copies
    logic [5:0]  len_reg;
    logic [63:0] word_reg [NUM_BWORDS];
    bit          in_cand;
    int          held_cnt;
    logic [7:0]  held [BOUND_BYTES];

    logic [7:0] feed_q [$];
    t_result    pending_results [$];
    t_result    want;
    int         fail_count = 0;

    bit   beat_taken = 1'b0;
    bit   steady     = 1'b0;
    int   burst_left = 1;
    int   gap_left   = 0;
    int   stall_mode = 0;
    int   stall_pos  = 0;
    logic [31:0] stall_pat = '0;

    function automatic int scan_len();
        int l;
        l = len_reg;
        if (l < 2) l = 2;
        if (l > BOUND_BYTES) l = BOUND_BYTES;
        return l;
    endfunction

    function automatic logic [7:0] bound_byte(input int i);
        return word_reg[i / 8][(i % 8) * 8 +: 8];
    endfunction

    task automatic push_result(input logic kind, input logic [7:0] data, input logic last);
        t_result r;
        r.kind = kind;
        r.data = data;
        r.last = last;
        pending_results.push_back(r);
    endtask

    task automatic scan_body_byte(input logic [7:0] b);
        int  len;
        int  k;
        bit  hit;
        len = scan_len();
        if (!in_cand) begin
            if (b == DASH_CHAR) begin
                in_cand  = 1'b1;
                held[0]  = b;
                held_cnt = 1;
            end else begin
                push_result(KIND_CONTENT, b, 1'b1);
            end
            return;
        end
        if (held_cnt < BOUND_BYTES) held[held_cnt] = b;
        held_cnt++;
        if (held_cnt < len) return;
        hit = (held_cnt == len);
        for (k = 0; hit && k < len; k++) begin
            if (held[k] != bound_byte(k)) hit = 1'b0;
        end
        if (hit) begin
            push_result(KIND_BOUNDARY, 8'h00, 1'b1);
        end else begin
            for (k = 0; k < held_cnt && k < BOUND_BYTES; k++) begin
                push_result(KIND_CONTENT, held[k], k == held_cnt - 1 || k == BOUND_BYTES - 1);
            end
        end
        in_cand  = 1'b0;
        held_cnt = 0;
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        fail_count++;
    endtask

    // result checking first, then prediction of the beat taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0b data %02h last %0b",
                                              o_m_tuser, o_m_tdata, o_m_tlast));
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tuser !== want.kind || o_m_tdata !== want.data ||
                        o_m_tlast !== want.last)
                        report_mismatch($sformatf(
                            "result kind %0b data %02h last %0b, wanted %0b %02h %0b",
                            o_m_tuser, o_m_tdata, o_m_tlast, want.kind, want.data, want.last));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                scan_body_byte(i_s_tdata);
                void'(feed_q.pop_front());
                beat_taken = 1'b1;
            end
        end
    end

    // body byte driver: bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || beat_taken) begin
            beat_taken = 1'b0;
            if (gap_left != 0 || feed_q.size() == 0) begin
                if (gap_left != 0) gap_left--;
                i_s_tvalid <= 1'b0;
                i_s_tdata  <= 8'($urandom_range(0, 255));
            end else begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= feed_q[0];
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = steady ? 0 : $urandom_range(0, 4);
                end
            end
        end
    end

    // result side stalls
    always @(negedge i_clk) begin
        if (stall_pos == 0) begin
            case (stall_mode)
                0:       stall_pat = '0;
                1:       stall_pat = $urandom & $urandom;
                default: stall_pat = $urandom;
            endcase
        end
        i_m_tready <= !stall_pat[stall_pos];
        stall_pos   = (stall_pos + 1) % 32;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_LEN:   len_reg = val[5:0];
            CFG_WORD0,
            CFG_WORD1,
            CFG_WORD2,
            CFG_WORD3: word_reg[2'(idx - CFG_WORD0)] = val;
            default:   ;
        endcase
    endtask

    task automatic wait_drained();
        while (feed_q.size() != 0 || pending_results.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // style: 0 printable, 1 random, 2 all ones after the leading dashes, 3 random with no leading dash
    task automatic load_boundary(input int len_val, input int style);
        logic [7:0]  bb [BOUND_BYTES];
        logic [63:0] w;
        int          i;
        int          j;
        for (i = 0; i < BOUND_BYTES; i++) begin
            case (style)
                0:       bb[i] = 8'($urandom_range(8'h21, 8'h7e));
                2:       bb[i] = 8'hff;
                default: bb[i] = 8'($urandom_range(0, 255));
            endcase
        end
        bb[0] = DASH_CHAR;
        bb[1] = DASH_CHAR;
        if (style == 3) bb[0] = "x";
        write_reg(CFG_LEN, 64'(len_val));
        for (i = 0; i < NUM_BWORDS; i++) begin
            for (j = 0; j < 8; j++) w[j * 8 +: 8] = bb[i * 8 + j];
            write_reg(CFG_IDX_W'(CFG_WORD0 + i), w);
        end
    endtask

    function automatic logic [7:0] any_byte();
        if ($urandom_range(0, 3) == 0) return DASH_CHAR;
        return 8'($urandom_range(0, 255));
    endfunction

    initial begin
        int          p;
        int          n;
        int          k;
        int          len;
        logic [7:0]  c;
        len_reg  = BLEN_RESET;
        for (k = 0; k < NUM_BWORDS; k++) word_reg[k] = '0;
        in_cand  = 1'b0;
        held_cnt = 0;
        steady     = 1'b1;
        stall_mode = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset boundary of zeros never matches
        feed_q.push_back(8'h00);
        feed_q.push_back(8'hff);
        feed_q.push_back(DASH_CHAR);
        feed_q.push_back("x");
        wait_drained();

        write_reg(CFG_LEN, 6);
        write_reg(CFG_WORD0, 64'h0000_6463_6261_2d2d);
        steady     = 1'b0;
        stall_mode = 1;
        feed_q.push_back("-"); feed_q.push_back("-"); feed_q.push_back("a");
        feed_q.push_back("b"); feed_q.push_back("c"); feed_q.push_back("d");
        feed_q.push_back("-"); feed_q.push_back("-"); feed_q.push_back("a");
        feed_q.push_back("b"); feed_q.push_back("c"); feed_q.push_back("e");
        feed_q.push_back("Z");
        feed_q.push_back("-"); feed_q.push_back("-"); feed_q.push_back("a");
        wait_drained();
        // length lowered to exactly the held count plus one: match
        write_reg(CFG_LEN, 4);
        feed_q.push_back("b");
        feed_q.push_back("-"); feed_q.push_back("-");
        wait_drained();
        // length lowered below the held count, also below the legal range
        write_reg(CFG_LEN, 1);
        feed_q.push_back("x");
        wait_drained();

        for (p = 0; p < 7; p++) begin
            case (p)
                0:       load_boundary(32, 0);
                1:       load_boundary(2, 1);
                2:       load_boundary($urandom_range(33, 63), 1);
                3:       load_boundary($urandom_range(0, 1), 3);
                4:       load_boundary($urandom_range(3, 31), 2);
                5:       load_boundary($urandom_range(3, 31), 0);
                default: load_boundary($urandom_range(3, 12), 1);
            endcase
            steady     = ($urandom_range(0, 2) == 0);
            stall_mode = $urandom_range(0, 2);
            len = scan_len();
            n   = 0;
            while (n < 14) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        for (k = 0; k < len; k++) feed_q.push_back(bound_byte(k));
                        n += len;
                    end
                    4, 5: begin
                        c = 8'($urandom_range(1, len - 1));
                        for (k = 0; k < c; k++) feed_q.push_back(bound_byte(k));
                        k = $urandom_range(0, 255);
                        if (k[7:0] == bound_byte(c)) k ^= 1;
                        feed_q.push_back(k[7:0]);
                        n += c + 1;
                    end
                    6, 7, 8: begin
                        c = 8'($urandom_range(1, 4));
                        for (k = 0; k < c; k++) feed_q.push_back(any_byte());
                        n += c;
                    end
                    default: begin
                        feed_q.push_back(DASH_CHAR);
                        feed_q.push_back(8'($urandom_range(0, 255)));
                        n += 2;
                    end
                endcase
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("multipart_boundary_scanner_test passed");
        else
            $display("multipart_boundary_scanner_test failed");
        $finish;
    end

    initial begin
        #400000;
        $display("multipart_boundary_scanner_test failed");
        $finish;
    end

endmodule
